// ----- src/ult_pkg.sv -----
// ----------------------------------------------------------------------------
// ult_pkg
// Shared types and constants of the unsorted list table.
// ----------------------------------------------------------------------------
package ult_pkg;

    localparam int CAPACITY   = 16;
    localparam int ITEM_WIDTH = 32;

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    // fixed field widths of the transaction ports
    localparam int OP_W    = 3;
    localparam int FIELD_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DELETE   = 3'd1,
        OP_RETRIEVE = 3'd2,
        OP_GET_NEXT = 3'd3,
        OP_RST_CUR  = 3'd4,
        OP_EMPTY    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PAST_END  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_GETN
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] item;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [FIELD_W-1:0] item_out;
        logic [COUNT_W-1:0] count;
        logic               is_full;
    } t_rsp;

endpackage

// ----- src/ult_ram.sv -----
// ----------------------------------------------------------------------------
// ult_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ult_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/unsorted_list_table.sv -----
// ----------------------------------------------------------------------------
// unsorted_list_table
// Fixed-capacity unsorted list with linear search, held in one RAM.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single result
// appears on o_rsp for one cycle with o_valid high and cannot be held off.
// Insert, reset cursor, make empty, undefined ops and every error that needs
// no search give their result in the cycle after start. Get next reads the
// entry at the cursor and shows it from the GETN state. Retrieve and delete
// search the entries in order from position 0 until a hit or the last one;
// a delete hit also fetches the last entry and writes it over the hit in
// the MOVE state. The list RAM has one read port, so the search checks one
// entry per cycle. A new start may be given in the cycle the result is shown.
// Entries are not cleared at reset; only entries below the count are used.
// ----------------------------------------------------------------------------
module unsorted_list_table
    import ult_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cursor, n_cursor;
    logic                  r_valid, n_valid;
    t_rsp                  r_rsp, n_rsp;
    t_op                   r_op, n_op;
    logic [ITEM_WIDTH-1:0] r_key, n_key;
    logic [ADDR_W-1:0]     r_idx, n_idx;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0]      last_pos;
    logic                  scan_hit;
    logic                  scan_last;
    logic                  accept;

    ult_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign last_pos  = r_count - CNT_W'(1);
    assign scan_hit  = (ram_rdata == r_key);
    assign scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        r_op  <= n_op;
        r_key <= n_key;
        r_idx <= n_idx;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_valid   = 1'b0;
        n_op      = r_op;
        n_key     = r_key;
        n_idx     = r_idx;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_count[ADDR_W-1:0];
        ram_wdata = r_key;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op           = t_op'(i_req.op);
                    n_key          = ITEM_WIDTH'(i_req.item);
                    n_idx          = '0;
                    n_rsp.status   = ST_OK;
                    n_rsp.found    = 1'b0;
                    n_rsp.item_out = '0;
                    unique case (t_op'(i_req.op))
                        OP_INSERT: begin
                            n_valid = 1'b1;
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = ITEM_WIDTH'(i_req.item);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_DELETE, OP_RETRIEVE: begin
                            if (r_count == '0) begin
                                n_valid      = 1'b1;
                                n_rsp.status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_GET_NEXT: begin
                            if (r_cursor < r_count) begin
                                ram_raddr = r_cursor[ADDR_W-1:0];
                                n_state   = S_GETN;
                            end else begin
                                n_valid      = 1'b1;
                                n_rsp.status = ST_PAST_END;
                            end
                        end
                        OP_RST_CUR: begin
                            n_valid  = 1'b1;
                            n_cursor = '0;
                        end
                        OP_EMPTY: begin
                            n_valid = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // ram_rdata holds entry r_idx
                ram_raddr = r_idx + ADDR_W'(1);
                if (scan_hit) begin
                    if (r_op == OP_DELETE) begin
                        ram_raddr = last_pos[ADDR_W-1:0];
                        n_state   = S_MOVE;
                    end else begin
                        n_valid        = 1'b1;
                        n_rsp.found    = 1'b1;
                        n_rsp.item_out = FIELD_W'(ram_rdata);
                        n_state        = S_IDLE;
                    end
                end else if (scan_last) begin
                    n_valid      = 1'b1;
                    n_rsp.status = ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_MOVE: begin
                // last entry fills the hole; harmless when the hit was the last
                ram_we      = 1'b1;
                ram_waddr   = r_idx;
                ram_wdata   = ram_rdata;
                n_count     = last_pos;
                n_valid     = 1'b1;
                n_rsp.found = 1'b1;
                n_state     = S_IDLE;
            end
            S_GETN: begin
                n_valid        = 1'b1;
                n_rsp.item_out = FIELD_W'(ram_rdata);
                n_cursor       = r_cursor + CNT_W'(1);
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.count   = COUNT_W'(n_count);
        n_rsp.is_full = (n_count == CNT_W'(CAPACITY));
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count beyond capacity");

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("search index past end of list");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while a transaction is in flight");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.found) |-> (o_rsp.status == ST_OK))
        else $error("found flagged with error status");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (t_op'(i_req.op) == OP_INSERT) && (r_count < CNT_W'(CAPACITY)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

endmodule

// ----- tb/sv/ult_list_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ult_list_checker
// Watches the request and result channels of the unsorted list table, keeps
// its own image of the list, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module ult_list_checker
    import ult_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_valid,
    input  t_rsp i_rsp,
    output int   o_fails,
    output int   o_pending
);

    localparam logic [63:0] KEY_MASK = (64'd1 << ITEM_WIDTH) - 64'd1;

    logic [FIELD_W-1:0] slot_mem [CAPACITY];
    int unsigned        used_n   = 0;
    int unsigned        cursor_n = 0;

    t_rsp rsp_q [$];
    t_rsp want;
    int   fails = 0;

    // Apply one operation to the list image and return the result it gives.
    function automatic t_rsp list_apply(input t_req rq);
        t_rsp               r;
        int                 hit_at;
        logic [FIELD_W-1:0] key;
        r      = '0;
        hit_at = -1;
        key    = rq.item & KEY_MASK[FIELD_W-1:0];
        for (int i = 0; i < used_n; i++) begin
            if (hit_at < 0 && slot_mem[i] == key) hit_at = i;
        end
        r.status = ST_OK;
        case (rq.op)
            OP_INSERT: begin
                if (used_n >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    slot_mem[used_n] = key;
                    used_n++;
                end
            end
            OP_DELETE: begin
                if (hit_at >= 0) begin
                    r.found          = 1'b1;
                    slot_mem[hit_at] = slot_mem[used_n - 1];
                    used_n--;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_RETRIEVE: begin
                if (hit_at >= 0) begin
                    r.found    = 1'b1;
                    r.item_out = slot_mem[hit_at];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_GET_NEXT: begin
                if (cursor_n < used_n) begin
                    r.item_out = slot_mem[cursor_n];
                    cursor_n++;
                end else begin
                    r.status = ST_PAST_END;
                end
            end
            OP_RST_CUR: cursor_n = 0;
            OP_EMPTY:   used_n = 0;
            default: ;
        endcase
        r.count   = COUNT_W'(used_n);
        r.is_full = (used_n == CAPACITY);
        return r;
    endfunction

    // Results are compared before the new request is logged: a result never
    // shows up in the cycle its own request is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (rsp_q.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("%0t: result with no transaction pending", $realtime);
                end else begin
                    want = rsp_q.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.found !== want.found ||
                        i_rsp.item_out !== want.item_out || i_rsp.count !== want.count ||
                        i_rsp.is_full !== want.is_full) begin
                        fails = fails + 1;
                        if (fails <= 10) begin
                            $write("%0t: mismatch exp st=%0d fnd=%0d item=%h cnt=%0d full=%0d ",
                                   $realtime, want.status, want.found, want.item_out,
                                   want.count, want.is_full);
                            $display("got st=%0d fnd=%0d item=%h cnt=%0d full=%0d",
                                     i_rsp.status, i_rsp.found, i_rsp.item_out,
                                     i_rsp.count, i_rsp.is_full);
                        end
                    end
                end
            end
            if (i_start && !i_busy) rsp_q.push_back(list_apply(i_req));
        end
        o_fails   <= fails;
        o_pending <= rsp_q.size();
    end

endmodule

// ----- tb/sv/tb_unsorted_list_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unsorted_list_table
// Drives directed and random list operations into the unsorted list table
// with random idle bursts; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_unsorted_list_table;
    import ult_pkg::*;

    localparam int N_ITEMS    = 850;
    localparam int TAIL_ITEMS = 60;
    localparam int WD_LIMIT   = 1000;
    localparam int DRAIN_CYC  = CAPACITY + 6;
    localparam int POOL_N     = 12;

    // op codes the block leaves undefined
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    int chk_fails;
    int chk_pending;
    int n_sent   = 0;
    int idle_cyc = 0;
    bit gaps_on  = 1'b0;

    logic [FIELD_W-1:0] pool [POOL_N];

    unsorted_list_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    ult_list_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (i_req),
        .i_valid   (o_valid),
        .i_rsp     (o_rsp),
        .o_fails   (chk_fails),
        .o_pending (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Nothing taken on either side for too long means the block is stuck.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cyc <= 0;
            end else if (idle_cyc >= WD_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cyc <= idle_cyc + 1;
            end
        end
    end

    // Start stays high into the next transaction unless an idle burst follows.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] val);
        t_req rq;
        rq.op   = op;
        rq.item = val;
        start <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (busy);
        if (op <= OP_EMPTY) n_sent++;
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Mostly pool values so searches hit; now and then a fresh word.
    function automatic logic [FIELD_W-1:0] pick_item();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    function automatic logic [OP_W-1:0] mix_op();
        int w;
        w = $urandom_range(0, 29);
        if (w < 9)  return OP_INSERT;
        if (w < 15) return OP_DELETE;
        if (w < 23) return OP_RETRIEVE;
        if (w < 27) return OP_GET_NEXT;
        if (w < 29) return OP_RST_CUR;
        return OP_EMPTY;
    endfunction

    initial begin
        int len;
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_N; i++) pool[i] = $urandom;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extremes, duplicates, cursor corners, bad ops
        gaps_on = 1'b1;
        send_req(OP_GET_NEXT, '0);
        send_req(OP_RETRIEVE, '1);
        send_req(OP_DELETE, '0);
        send_req(OP_INSERT, '0);
        send_req(OP_INSERT, '1);
        send_req(OP_INSERT, '0);
        send_req(OP_RETRIEVE, '1);
        send_req(OP_RETRIEVE, '0);
        send_req(OP_DELETE, '0);
        send_req(OP_GET_NEXT, '1);
        send_req(OP_GET_NEXT, '0);
        send_req(OP_GET_NEXT, '0);
        send_req(OP_RST_CUR, '1);
        send_req(OP_GET_NEXT, '0);
        send_req(OP_EMPTY, '0);
        send_req(OP_GET_NEXT, '0);
        send_req(OP_RST_CUR, '0);
        send_req(OP_RSVD6, '1);
        send_req(OP_RSVD7, '0);
        send_req(OP_DELETE, '1);

        while (n_sent < N_ITEMS) begin
            gaps_on = (n_sent < N_ITEMS - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // fill up to and past capacity
                    len = $urandom_range(CAPACITY - 2, CAPACITY + 2);
                    repeat (len) send_req(OP_INSERT, pick_item());
                end
                2, 3, 4, 5: begin
                    len = $urandom_range(8, 20);
                    repeat (len) send_req(mix_op(), pick_item());
                end
                6, 7: begin
                    // cursor walk through the list and beyond its end
                    send_req(OP_RST_CUR, pick_item());
                    len = $urandom_range(1, CAPACITY + 2);
                    repeat (len) send_req(OP_GET_NEXT, pick_item());
                end
                8: begin
                    len = $urandom_range(4, 10);
                    repeat (len) send_req(OP_W'($urandom_range(0, 7)), $urandom);
                end
                default: begin
                    send_req(OP_EMPTY, $urandom);
                    len = $urandom_range(1, 5);
                    repeat (len) send_req(OP_INSERT, pick_item());
                end
            endcase
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
